/* design/word_hash_table_lookup_insert_core_macros.svh */
// Assertion helpers for the word hash table core
`ifndef WORD_HASH_TABLE_LOOKUP_INSERT_CORE_MACROS_SVH
`define WORD_HASH_TABLE_LOOKUP_INSERT_CORE_MACROS_SVH

// same-cycle implication
`define WHT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication
`define WHT_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
    else $error("assertion failed");

`endif

/* design/wht_pkg.sv */
package wht_pkg;

  localparam int TABLE_DEPTH    = 4096;
  localparam int MAX_WORD_BYTES = 32;
  localparam int ADDR_W         = $clog2(TABLE_DEPTH);
  localparam int SIZE_W         = ADDR_W + 1;
  localparam int LEN_W          = $clog2(MAX_WORD_BYTES) + 1;
  localparam int BIDX_W         = $clog2(MAX_WORD_BYTES);
  localparam int ENTRY_W        = 1 + LEN_W + 8 * MAX_WORD_BYTES;

  localparam logic [31:0] HASH_SEED = 32'd1159241;
  localparam int          HASH_BITS = 31;
  localparam int          STEP_BITS = 7;
  localparam logic [STEP_BITS-1:0] PROBE_STEP = 7'd101;
  localparam int          DCNT_W    = 5;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef struct packed {
    logic acc;
    logic start;
    logic long_out;
    logic div_run;
    logic cap_home;
    logic step_load;
    logic cap_step;
    logic mem_rd;
    logic probe_next;
    logic insert;
    logic emit_found;
    logic emit_full;
    logic clr_wr;
  } wht_cmd_t;

  typedef struct packed {
    logic word_long;
    logic div_last;
    logic clr_last;
    logic slot_valid;
    logic slot_match;
    logic probes_last;
    logic out_busy;
  } wht_sts_t;

endpackage

/* design/wht_ctrl.sv */
module wht_ctrl
  import wht_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last_byte,
  output logic     in_ready,
  output wht_cmd_t cmd,
  input  wht_sts_t sts
);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_HDIV = 6'b000100,
    S_SDIV = 6'b001000,
    S_RD   = 6'b010000,
    S_CMP  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_ready = (state_r == S_IDLE) && (!sts.out_busy || !in_last_byte);
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          cmd.acc = 1'b1;
          if (in_last_byte) begin
            if (sts.word_long) begin
              cmd.long_out = 1'b1;
            end else begin
              cmd.start = 1'b1;
              state_nxt = S_HDIV;
            end
          end
        end
      end
      S_HDIV: begin
        cmd.div_run = 1'b1;
        if (sts.div_last) begin
          cmd.cap_home  = 1'b1;
          cmd.step_load = 1'b1;
          state_nxt     = S_SDIV;
        end
      end
      S_SDIV: begin
        cmd.div_run = 1'b1;
        if (sts.div_last) begin
          cmd.cap_step = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        if (!sts.slot_valid) begin
          cmd.insert = 1'b1;
          state_nxt  = S_IDLE;
        end else if (sts.slot_match) begin
          cmd.emit_found = 1'b1;
          state_nxt      = S_IDLE;
        end else if (sts.probes_last) begin
          cmd.emit_full = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_RD;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

endmodule

/* design/wht_datapath.sv */
`include "word_hash_table_lookup_insert_core_macros.svh"

module wht_datapath
  import wht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_word_byte,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_table_size,
  input  wht_cmd_t          cmd,
  output wht_sts_t          sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_slot_address,
  output logic [SIZE_W-1:0] out_element_count
);

  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] n_act;

  logic [31:0]       hash_r, hash_nxt;
  logic [LEN_W-1:0]  len_r, plen_r;
  logic              too_long_r;
  logic [MAX_WORD_BYTES-1:0][7:0] wbuf_r;

  logic [HASH_BITS-1:0] q_r;
  logic [SIZE_W-1:0]    rem_r, rem_nxt;
  logic [SIZE_W:0]      trial;
  logic [DCNT_W-1:0]    dcnt_r;

  logic [ADDR_W-1:0]    addr_r, home_r, probes_r;
  logic [ADDR_W-1:0]    step_r;
  logic [SIZE_W-1:0]    adv_sum, adv_sub;
  logic [ADDR_W-1:0]    adv_addr;
  logic [SIZE_W-1:0]    count_r;
  logic [ADDR_W-1:0]    clr_addr_r;

  logic [ENTRY_W-1:0]   mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]   rd_data_r, wr_data;
  logic                 mem_we;
  logic [ADDR_W-1:0]    wr_addr;

  logic                         rd_valid;
  logic [LEN_W-1:0]             rd_len;
  logic [MAX_WORD_BYTES-1:0][7:0] rd_word;
  logic [MAX_WORD_BYTES-1:0]    byte_eq;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [SIZE_W-1:0] out_count_r;

  always_comb begin
    if (size_r == '0)                           n_act = SIZE_W'(1);
    else if (size_r > SIZE_W'(TABLE_DEPTH))     n_act = SIZE_W'(TABLE_DEPTH);
    else                                        n_act = size_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)         size_r <= SIZE_W'(TABLE_DEPTH);
    else if (cfg_wr_en) size_r <= cfg_table_size;
  end

  // shift-add-xor hash, byte taken as signed
  assign hash_nxt = hash_r ^ ((hash_r << 5) + {{24{in_word_byte[7]}}, in_word_byte}
                    + (hash_r >> 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r     <= HASH_SEED;
      len_r      <= '0;
      too_long_r <= 1'b0;
    end else if (cmd.acc) begin
      if (cmd.start || cmd.long_out) begin
        hash_r     <= HASH_SEED;
        len_r      <= '0;
        too_long_r <= 1'b0;
      end else begin
        hash_r <= hash_nxt;
        if (len_r == LEN_W'(MAX_WORD_BYTES)) too_long_r <= 1'b1;
        else                                 len_r      <= len_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && len_r != LEN_W'(MAX_WORD_BYTES)) wbuf_r[len_r[BIDX_W-1:0]] <= in_word_byte;
    if (cmd.start) plen_r <= len_r + 1'b1;
  end

  // restoring divider, one quotient bit per cycle
  assign trial   = {rem_r, q_r[HASH_BITS-1]};
  assign rem_nxt = (trial >= {1'b0, n_act}) ? SIZE_W'(trial - {1'b0, n_act})
                                            : SIZE_W'(trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.start) begin
      q_r    <= hash_nxt[HASH_BITS-1:0];
      rem_r  <= '0;
      dcnt_r <= DCNT_W'(HASH_BITS);
    end else if (cmd.step_load) begin
      q_r    <= {PROBE_STEP, {(HASH_BITS-STEP_BITS){1'b0}}};
      rem_r  <= '0;
      dcnt_r <= DCNT_W'(STEP_BITS);
    end else if (cmd.div_run) begin
      q_r    <= {q_r[HASH_BITS-2:0], 1'b0};
      rem_r  <= rem_nxt;
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  assign adv_sum  = {1'b0, addr_r} + {1'b0, step_r};
  assign adv_sub  = adv_sum - n_act;
  assign adv_addr = (adv_sum >= n_act) ? adv_sub[ADDR_W-1:0] : adv_sum[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.cap_home) begin
      home_r   <= rem_nxt[ADDR_W-1:0];
      addr_r   <= rem_nxt[ADDR_W-1:0];
      probes_r <= '0;
    end else if (cmd.probe_next) begin
      addr_r   <= adv_addr;
      probes_r <= probes_r + 1'b1;
    end
    if (cmd.cap_step) step_r <= rem_nxt[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          clr_addr_r <= '0;
    else if (cmd.clr_wr) clr_addr_r <= clr_addr_r + 1'b1;
  end

  assign mem_we  = cmd.clr_wr || cmd.insert;
  assign wr_addr = cmd.clr_wr ? clr_addr_r : addr_r;
  assign wr_data = cmd.clr_wr ? '0 : {1'b1, plen_r, wbuf_r};

  always_ff @(posedge clk) begin
    if (mem_we)     mem[wr_addr] <= wr_data;
    if (cmd.mem_rd) rd_data_r    <= mem[addr_r];
  end

  assign {rd_valid, rd_len, rd_word} = rd_data_r;

  always_comb begin
    for (int i = 0; i < MAX_WORD_BYTES; i++) begin
      byte_eq[i] = (rd_word[i] == wbuf_r[i]) || (LEN_W'(i) >= plen_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          count_r <= '0;
    else if (cmd.insert) count_r <= count_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.long_out || cmd.insert || cmd.emit_found || cmd.emit_full) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.long_out) begin
      out_status_r <= ST_TOO_LONG;
      out_addr_r   <= '0;
      out_count_r  <= count_r;
    end else if (cmd.insert) begin
      out_status_r <= ST_INSERTED;
      out_addr_r   <= addr_r;
      out_count_r  <= count_r + 1'b1;
    end else if (cmd.emit_found) begin
      out_status_r <= ST_FOUND;
      out_addr_r   <= addr_r;
      out_count_r  <= count_r;
    end else if (cmd.emit_full) begin
      out_status_r <= ST_FULL;
      out_addr_r   <= home_r;
      out_count_r  <= count_r;
    end
  end

  assign sts.word_long   = too_long_r || (len_r == LEN_W'(MAX_WORD_BYTES));
  assign sts.div_last    = (dcnt_r == DCNT_W'(1));
  assign sts.clr_last    = (clr_addr_r == '1);
  assign sts.slot_valid  = rd_valid;
  assign sts.slot_match  = (rd_len == plen_r) && (&byte_eq);
  assign sts.probes_last = ({1'b0, probes_r} == n_act - 1'b1);
  assign sts.out_busy    = out_valid_r;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot_address  = out_addr_r;
  assign out_element_count = out_count_r;

  `WHT_ASSERT_IMP(a_probe_in_range, clk, rst_n, cmd.mem_rd, {1'b0, addr_r} < n_act)
  `WHT_ASSERT_NXT(a_step_in_range, clk, rst_n, cmd.cap_step, {1'b0, step_r} < n_act)
  `WHT_ASSERT_NXT(a_insert_reported, clk, rst_n, cmd.insert,
                  out_valid_r && out_status_r == ST_INSERTED)
  `WHT_ASSERT_IMP(a_count_bound, clk, rst_n, cmd.insert, count_r < SIZE_W'(TABLE_DEPTH))

endmodule

/* design/word_hash_table_lookup_insert_core.sv */
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_word_byte, in_last_byte
// out      out_valid / out_ready  out_status, out_slot_address, out_element_count
// cfg      cfg_wr_en              cfg_table_size
//
// After reset a clearing pass writes all 4096 slots of the table empty; no item is taken then.
// Bytes that are not last are taken one per cycle while no lookup is under way.
// A last byte runs the home-slot divider, then the probe-step divider, then a table read
// and a compare per probe; a too-long word answers at once.
// A last byte waits while the previous result is still held on the out channel.
module word_hash_table_lookup_insert_core
  import wht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_word_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_slot_address,
  output logic [SIZE_W-1:0] out_element_count,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_table_size
);

  wht_cmd_t cmd;
  wht_sts_t sts;

  wht_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  wht_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_word_byte      (in_word_byte),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_table_size    (cfg_table_size),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot_address  (out_slot_address),
    .out_element_count (out_element_count)
  );

endmodule

/* test/word_hash_table_lookup_insert_core_tb.sv */
module word_hash_table_lookup_insert_core_tb;
  import wht_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] count;
  } lookup_res_t;

  localparam int IDLE_LIMIT = 40000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_word_byte;
  logic              in_last_byte;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_status;
  logic [ADDR_W-1:0] out_slot_address;
  logic [SIZE_W-1:0] out_element_count;
  logic              cfg_wr_en;
  logic [SIZE_W-1:0] cfg_table_size;

  word_hash_table_lookup_insert_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_word_byte(in_word_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_slot_address(out_slot_address),
    .out_element_count(out_element_count),
    .cfg_wr_en(cfg_wr_en), .cfg_table_size(cfg_table_size)
  );

  // predictor state
  logic [SIZE_W-1:0] tbl_size;
  logic [31:0]       hash_acc;
  logic [7:0]        cur_word [MAX_WORD_BYTES];
  int                cur_len;
  bit                cur_long;
  bit                tbl_valid [TABLE_DEPTH];
  int                tbl_len [TABLE_DEPTH];
  logic [7:0]        tbl_word [TABLE_DEPTH][MAX_WORD_BYTES];
  int                tbl_count;

  byte_item_t  pending_bytes[$];
  lookup_res_t expected_res[$];
  int          errors;
  int          status_seen [4];
  int          items_sent;
  bit          in_fire, out_fire;
  int          in_gap, out_gap;
  int          hold_left;
  bit          hold_req;
  int          idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int eff_size();
    if (tbl_size == 0) return 1;
    if (tbl_size > TABLE_DEPTH) return TABLE_DEPTH;
    return tbl_size;
  endfunction

  function automatic bit slot_same(int a);
    if (tbl_len[a] != cur_len) return 0;
    for (int i = 0; i < cur_len; i++)
      if (tbl_word[a][i] != cur_word[i]) return 0;
    return 1;
  endfunction

  task automatic hash_byte(input logic [7:0] b, input logic last);
    logic [31:0] c;
    lookup_res_t r;
    int n, home, a;
    c = {{24{b[7]}}, b};
    hash_acc = hash_acc ^ ((hash_acc << 5) + c + (hash_acc >> 2));
    if (cur_len < MAX_WORD_BYTES) begin
      cur_word[cur_len] = b;
      cur_len++;
    end else begin
      cur_long = 1;
    end
    if (!last) return;
    r.addr = '0;
    if (cur_long) begin
      r.status = ST_TOO_LONG;
    end else begin
      n = eff_size();
      home = (hash_acc & 32'h7fffffff) % n;
      a = home;
      r.status = ST_FULL;
      for (int p = 0; p < n; p++) begin
        if (!tbl_valid[a]) begin
          tbl_valid[a] = 1;
          tbl_len[a] = cur_len;
          for (int i = 0; i < cur_len; i++) tbl_word[a][i] = cur_word[i];
          tbl_count++;
          r.status = ST_INSERTED;
          break;
        end
        if (slot_same(a)) begin
          r.status = ST_FOUND;
          break;
        end
        a = (a + 101) % n;
      end
      r.addr = (r.status == ST_FULL) ? home[ADDR_W-1:0] : a[ADDR_W-1:0];
    end
    r.count = tbl_count[SIZE_W-1:0];
    expected_res.push_back(r);
    hash_acc = HASH_SEED;
    cur_len = 0;
    cur_long = 0;
  endtask

  // monitor and predictor
  always @(posedge clk) begin
    lookup_res_t e;
    in_fire <= rst_n && in_valid && in_ready;
    out_fire <= rst_n && out_valid && out_ready;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        status_seen[out_status]++;
        if (expected_res.size() == 0) begin
          report("unexpected item status", out_status, -1);
        end else begin
          e = expected_res.pop_front();
          if (out_status != e.status) report("status", out_status, e.status);
          if (out_slot_address != e.addr) report("slot_address", out_slot_address, e.addr);
          if (out_element_count != e.count) report("element_count", out_element_count, e.count);
        end
      end
      if (in_valid && in_ready) hash_byte(in_word_byte, in_last_byte);
      if (cfg_wr_en) tbl_size = cfg_table_size;
    end
  end

  // sender
  always @(negedge clk) begin
    byte_item_t it;
    if (rst_n && (!in_valid || in_fire)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        it = pending_bytes.pop_front();
        in_word_byte <= it.b;
        in_last_byte <= it.last;
        in_valid <= 1'b1;
        in_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    int gap_draw;
    if (rst_n) begin
      if (hold_req && hold_left == 0) begin
        hold_left <= 300;
        hold_req <= 1'b0;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_fire) begin
        gap_draw = $urandom_range(0, 3);
        out_gap <= (gap_draw > 0) ? gap_draw - 1 : 0;
        out_ready <= (gap_draw == 0);
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d items outstanding", expected_res.size());
      $display("FAIL");
      $finish;
    end
  end

  logic [7:0] vocab [16][8];
  int         vocab_len [16];

  task automatic add_word(input int len, input int vidx, input int fill);
    byte_item_t it;
    for (int i = 0; i < len; i++) begin
      if (vidx >= 0) it.b = vocab[vidx][i];
      else if (fill >= 0) it.b = fill[7:0];
      else it.b = 8'($urandom_range(0, 255));
      it.last = (i == len - 1);
      pending_bytes.push_back(it);
      items_sent++;
    end
  endtask

  task automatic drain();
    wait (pending_bytes.size() == 0 && expected_res.size() == 0 && !in_valid);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_size(input int s);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_table_size <= s[SIZE_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(input int nitems);
    int target, k;
    target = items_sent + nitems;
    while (items_sent < target) begin
      k = $urandom_range(0, 99);
      if (k < 55) add_word(vocab_len[$urandom_range(0, 15)], -1, -1);
      else if (k < 60) add_word($urandom_range(30, 40), -1, -1);
      else add_word($urandom_range(1, 8), -1, -1);
    end
  endtask

  initial begin
    int sizes [7];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word_byte = '0;
    in_last_byte = 1'b0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_table_size = '0;
    errors = 0;
    items_sent = 0;
    in_gap = 0;
    out_gap = 0;
    hold_left = 0;
    hold_req = 0;
    idle_cycles = 0;
    tbl_size = 13'd4096;
    hash_acc = HASH_SEED;
    cur_len = 0;
    cur_long = 0;
    tbl_count = 0;
    foreach (tbl_valid[i]) tbl_valid[i] = 0;
    foreach (vocab_len[i]) begin
      vocab_len[i] = $urandom_range(1, 6);
      foreach (vocab[i][j]) vocab[i][j] = 8'($urandom_range(0, 255));
    end
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes at reset size
    add_word(1, -1, 0);
    add_word(1, -1, 255);
    add_word(3, -1, 128);
    add_word(3, -1, 127);
    add_word(1, -1, 0);
    add_word(32, -1, -1);
    add_word(33, -1, 90);
    add_word(40, -1, -1);
    add_word(vocab_len[0], 0, -1);
    add_word(vocab_len[0], 0, -1);
    drain();
    // size one: insert, found, then full; zero behaves as one
    set_size(1);
    add_word(2, -1, 7);
    add_word(2, -1, 7);
    add_word(2, -1, 8);
    drain();
    set_size(0);
    add_word(2, -1, 8);
    add_word(2, -1, 7);
    drain();
    // oversize clamps to full depth
    set_size(8191);
    add_word(2, -1, 9);
    add_word(2, -1, 7);
    drain();

    // long receiver hold while bytes keep coming
    hold_req = 1'b1;
    random_phase(120);
    drain();

    sizes = '{7, 101, 202, 2, 4096, 33, 13};
    foreach (sizes[i]) begin
      set_size(sizes[i]);
      random_phase(90);
      drain();
    end
    set_size($urandom_range(1, 64));
    random_phase(60);
    drain();

    $display("sent %0d bytes over sizes 0..8191, holds and random gaps", items_sent);
    $display("found %0d inserted %0d full %0d too long %0d",
             status_seen[ST_FOUND], status_seen[ST_INSERTED],
             status_seen[ST_FULL], status_seen[ST_TOO_LONG]);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
